// ===== src/stqz_pkg.sv =====
// Shared constants and types for the sextant two-color quantizer.
`default_nettype none

package stqz_pkg;

  localparam int NUM_PIXELS = 6;
  localparam int PIXEL_W    = 32;
  localparam int IN_DATA_W  = NUM_PIXELS * PIXEL_W;
  // mask + fore + back = 70 bits, padded to 9 bytes
  localparam int OUT_FIELDS_W = NUM_PIXELS + 2 * PIXEL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [PIXEL_W-1:0]    pixel_t;
  typedef logic [NUM_PIXELS-1:0] mask_t;

endpackage

`default_nettype wire

// ===== src/stqz_absdiff.sv =====
// Unsigned absolute difference of two pixel words.
`default_nettype none

module stqz_absdiff (
  input  var stqz_pkg::pixel_t a,
  input  var stqz_pkg::pixel_t b,
  output var stqz_pkg::pixel_t gap
);

  logic [stqz_pkg::PIXEL_W:0] diff_ab;

  assign diff_ab = {1'b0, a} - {1'b0, b};
  // borrow out means b > a
  assign gap = diff_ab[stqz_pkg::PIXEL_W] ? (b - a) : diff_ab[stqz_pkg::PIXEL_W-1:0];

endmodule

`default_nettype wire

// ===== src/sextant_two_color_quantizer_core.sv =====
// Top level: three-stage pipelined two-color quantizer for one 2x3 pixel block.
//
//  channel  dir  beat fields (low bit first)
//  s_*      in   s_tdata: pixel_0 .. pixel_5, 32 bits each (192 bits)
//  m_*      out  m_tdata: glyph_mask(6), fore_color(32), back_color(32), 2 zero bits
//
//  One beat per cycle while m_tready stays high.
//  Stage 1 picks the background color, stage 2 forms the twelve distances,
//  stage 3 compares them and holds the result as the output register.
//  Each stage has its own valid bit and takes data when it is empty or draining,
//  so a stall on m_tready backs up stage by stage without losing beats.
//  rst clears the valid bits only.
`default_nettype none

module sextant_two_color_quantizer_core (
  input  var logic                              clk,
  input  var logic                              rst,
  input  var logic                              s_tvalid,
  output var logic                              s_tready,
  // pixel_0 [31:0], pixel_1 .. pixel_5 in following 32-bit slots
  input  var logic [stqz_pkg::IN_DATA_W-1:0]    s_tdata,
  output var logic                              m_tvalid,
  input  var logic                              m_tready,
  // glyph_mask [5:0], fore_color [37:6], back_color [69:38], zero [71:70]
  output var logic [stqz_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int N = stqz_pkg::NUM_PIXELS;

  stqz_pkg::pixel_t px_in [N];
  stqz_pkg::pixel_t back_c;

  // stage 1
  logic             v1;
  stqz_pkg::pixel_t px1 [N];
  stqz_pkg::pixel_t back1;
  logic             same1;

  // stage 2
  logic             v2;
  stqz_pkg::pixel_t fore2;
  stqz_pkg::pixel_t back2;
  logic             same2;
  stqz_pkg::pixel_t gap_f2 [N];
  stqz_pkg::pixel_t gap_b2 [N];

  // stage 3 (output)
  logic             v3;
  stqz_pkg::mask_t  mask3;
  stqz_pkg::pixel_t fore3;
  stqz_pkg::pixel_t back3;

  stqz_pkg::pixel_t gap_f [N];
  stqz_pkg::pixel_t gap_b [N];
  stqz_pkg::mask_t  mask_c;

  logic ready1, ready2, ready3;

  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  // first pixel that differs from pixel 0, else pixel 0
  always_comb begin
    for (int i = 0; i < N; i++) begin
      px_in[i] = s_tdata[i*stqz_pkg::PIXEL_W +: stqz_pkg::PIXEL_W];
    end
    back_c = px_in[0];
    for (int i = N - 1; i >= 1; i--) begin
      if (px_in[i] != px_in[0]) begin
        back_c = px_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_tvalid;
    end
    if (ready1 && s_tvalid) begin
      px1   <= px_in;
      back1 <= back_c;
      same1 <= (back_c == px_in[0]);
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_gap
    stqz_absdiff u_gap_f (.a(px1[g]), .b(px1[0]), .gap(gap_f[g]));
    stqz_absdiff u_gap_b (.a(px1[g]), .b(back1),  .gap(gap_b[g]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2 && v1) begin
      fore2  <= px1[0];
      back2  <= back1;
      same2  <= same1;
      gap_f2 <= gap_f;
      gap_b2 <= gap_b;
    end
  end

  // ties go to the background; a uniform block snaps everything to the foreground
  always_comb begin
    for (int i = 0; i < N; i++) begin
      mask_c[i] = same2 || (gap_f2[i] < gap_b2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
    if (ready3 && v2) begin
      mask3 <= mask_c;
      fore3 <= fore2;
      back3 <= back2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {{(stqz_pkg::OUT_DATA_W - stqz_pkg::OUT_FIELDS_W){1'b0}},
                     back3, fore3, mask3};

endmodule

`default_nettype wire

// ===== src/stqz_checker.sv =====
// Port-level checks for the two-color quantizer, bound to the top level.
`default_nettype none

module stqz_checker (
  input var logic                            clk,
  input var logic                            rst,
  input var logic                            s_tvalid,
  input var logic                            s_tready,
  input var logic                            m_tvalid,
  input var logic                            m_tready,
  input var logic [stqz_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int MW = stqz_pkg::NUM_PIXELS;
  localparam int PW = stqz_pkg::PIXEL_W;

  stqz_pkg::mask_t  mask_o;
  stqz_pkg::pixel_t fore_o;
  stqz_pkg::pixel_t back_o;
  logic             in_beat;

  assign mask_o  = m_tdata[MW-1:0];
  assign fore_o  = m_tdata[MW +: PW];
  assign back_o  = m_tdata[MW+PW +: PW];
  assign in_beat = s_tvalid && s_tready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_fore_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> mask_o[0])
    else $error("pixel 0 not marked foreground");

  a_uniform: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (fore_o == back_o) |-> (mask_o == {MW{1'b1}}))
    else $error("single-color block with cleared mask bit");

  // beat passes through the stage 1, stage 2 and stage 3 registers, visible as m_tvalid after that
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_beat && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("beat lost in free-flowing pipeline");

endmodule

bind sextant_two_color_quantizer_core stqz_checker u_stqz_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/stqz_check.sv =====
// Checker for the sextant quantizer: predicts each block's result and compares output beats.
`default_nettype none

module stqz_check
  import stqz_pkg::*;
(
  input  var logic                  clk,
  input  var logic                  rst,
  input  var logic                  s_tvalid,
  input  var logic                  s_tready,
  // pixel_0 [31:0], pixel_1 .. pixel_5 in following 32-bit slots
  input  var logic [IN_DATA_W-1:0]  s_tdata,
  input  var logic                  m_tvalid,
  input  var logic                  m_tready,
  // glyph_mask [5:0], fore_color [37:6], back_color [69:38], zero [71:70]
  input  var logic [OUT_DATA_W-1:0] m_tdata,
  output int                        errors,
  output int                        pending,
  output int                        checked
);

  // back_color in the top bits so glyph_mask lands at bit 0, as on m_tdata
  typedef struct packed {
    pixel_t back_color;
    pixel_t fore_color;
    mask_t  glyph_mask;
  } glyph_t;

  glyph_t expected_glyphs[$];
  glyph_t want;
  glyph_t got;

  function automatic pixel_t pixel_gap(pixel_t a, pixel_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic glyph_t quantize_block(logic [IN_DATA_W-1:0] blk);
    pixel_t px [NUM_PIXELS];
    glyph_t g;
    pixel_t snapped;
    logic   found;
    for (int i = 0; i < NUM_PIXELS; i++) px[i] = blk[i*PIXEL_W +: PIXEL_W];
    g.fore_color = px[0];
    g.back_color = px[0];
    found = 1'b0;
    for (int i = 1; i < NUM_PIXELS; i++) begin
      if (!found && px[i] != px[0]) begin
        g.back_color = px[i];
        found = 1'b1;
      end
    end
    // a tie goes to the background; with a uniform block both colors match anyway
    for (int i = 0; i < NUM_PIXELS; i++) begin
      snapped = (pixel_gap(g.fore_color, px[i]) < pixel_gap(g.back_color, px[i])) ?
                g.fore_color : g.back_color;
      g.glyph_mask[i] = (snapped == g.fore_color);
    end
    return g;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_glyphs.delete();
    end else begin
      // pop before push: an output beat can never belong to the same-edge input
      if (m_tvalid && m_tready) begin
        got = glyph_t'(m_tdata[OUT_FIELDS_W-1:0]);
        if (expected_glyphs.size() == 0) begin
          if (errors < 10)
            $display("ERROR: output beat with nothing expected: mask %h fore %h back %h",
                     got.glyph_mask, got.fore_color, got.back_color);
          errors++;
        end else begin
          want = expected_glyphs.pop_front();
          if (got.glyph_mask !== want.glyph_mask || got.fore_color !== want.fore_color ||
              got.back_color !== want.back_color) begin
            if (errors < 10)
              $display("ERROR: beat %0d: expected mask %h fore %h back %h, got mask %h fore %h back %h",
                       checked, want.glyph_mask, want.fore_color, want.back_color,
                       got.glyph_mask, got.fore_color, got.back_color);
            errors++;
          end
        end
        checked++;
      end
      if (s_tvalid && s_tready) expected_glyphs.push_back(quantize_block(s_tdata));
    end
    pending = expected_glyphs.size();
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench top: drives pixel blocks into the quantizer, stalls the output, gives the verdict.
`default_nettype none

module tb;
  import stqz_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 1232;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int   errors;
  int   pending;
  int   checked;
  int   sent = 0;
  int   directed = 0;
  int   idle_cycles = 0;
  int   ready_hold = 0;
  int   rx_wait;
  logic calm = 1'b0;

  sextant_two_color_quantizer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stqz_check u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side: after a beat, unless calm, hold tready low for a randomly drawn stall (none on a zero draw)
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) m_tready <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      rx_wait = calm ? 0 : $urandom_range(0, 17);
      if (rx_wait != 0) begin
        m_tready   <= 1'b0;
        ready_hold <= rx_wait;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles, %0d results pending",
                 IDLE_LIMIT, pending);
        $display("FAIL sextant_two_color_quantizer_core");
        $finish;
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack6(pixel_t p0, pixel_t p1, pixel_t p2,
                                                  pixel_t p3, pixel_t p4, pixel_t p5);
    return {p5, p4, p3, p2, p1, p0};
  endfunction

  function automatic pixel_t pick_extreme(pixel_t p0);
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return p0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_block();
    pixel_t   px [NUM_PIXELS];
    pixel_t   fg;
    pixel_t   bg;
    pixel_t   mid;
    logic [32:0] sum;
    int       first_diff;
    fg = $urandom;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < NUM_PIXELS; i++) px[i] = $urandom;
      end
      2, 3: begin
        // two-color palette with small offsets: background at any slot after pixel 0
        bg = ($urandom_range(0, 1) != 0) ? fg + $urandom_range(1, 300) : $urandom;
        px[0] = fg;
        for (int i = 1; i < NUM_PIXELS; i++) begin
          case ($urandom_range(0, 3))
            0: px[i] = fg;
            1: px[i] = bg;
            2: px[i] = fg + $urandom_range(0, 7) - 3;
            default: px[i] = bg + $urandom_range(0, 7) - 3;
          endcase
        end
      end
      4, 5, 6: begin
        // background has even distance, so the midpoint is an exact tie
        bg = $urandom;
        if ((fg[0] ^ bg[0]) != 1'b0) bg[0] = ~bg[0];
        if (bg == fg) bg = bg ^ 32'h2;
        sum = {1'b0, fg} + {1'b0, bg};
        mid = sum[32:1];
        first_diff = $urandom_range(1, NUM_PIXELS - 1);
        px[0] = fg;
        for (int i = 1; i < NUM_PIXELS; i++) begin
          if (i < first_diff) px[i] = fg;
          else if (i == first_diff) px[i] = bg;
          else begin
            case ($urandom_range(0, 5))
              0: px[i] = fg;
              1: px[i] = bg;
              2: px[i] = mid + 1;
              3: px[i] = mid - 1;
              4: px[i] = $urandom;
              default: px[i] = mid;
            endcase
          end
        end
      end
      7: begin
        // uniform block, or a run of the foreground color followed by random words
        first_diff = $urandom_range(1, NUM_PIXELS);
        for (int i = 0; i < NUM_PIXELS; i++) px[i] = (i < first_diff) ? fg : $urandom;
      end
      default: begin
        px[0] = pick_extreme(fg);
        for (int i = 1; i < NUM_PIXELS; i++) px[i] = pick_extreme(px[0]);
      end
    endcase
    return pack6(px[0], px[1], px[2], px[3], px[4], px[5]);
  endfunction

  task automatic send_block(input logic [IN_DATA_W-1:0] blk);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= blk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off input until every predicted result has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, uniform blocks and alternating bit patterns
    send_block(pack6('0, '0, '0, '0, '0, '0));
    send_block(pack6('1, '1, '1, '1, '1, '1));
    send_block(pack6(32'hDEADBEEF, 32'hDEADBEEF, 32'hDEADBEEF,
                     32'hDEADBEEF, 32'hDEADBEEF, 32'hDEADBEEF));
    send_block(pack6('0, '1, '1, '1, '1, '1));
    send_block(pack6('1, '0, '0, '0, '0, '0));
    send_block(pack6(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                     32'h55555555, 32'hAAAAAAAA, 32'h55555555));
    send_block(pack6(32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                     32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
    // full-range tie at the midpoint, neighbors on either side
    send_block(pack6(32'h0, 32'hFFFFFFFE, 32'h7FFFFFFF, 32'h7FFFFFFE, 32'h80000000, 32'h0));
    send_block(pack6('1, 32'h1, 32'h80000000, 32'h7FFFFFFF, 32'h80000001, 32'hFFFFFFFE));
    // first differing pixel at each slot, ties on the later slots
    send_block(pack6(32'd10, 32'd20, 32'd15, 32'd14, 32'd16, 32'd10));
    send_block(pack6(32'd10, 32'd10, 32'd20, 32'd15, 32'd14, 32'd16));
    send_block(pack6(32'd10, 32'd10, 32'd10, 32'd20, 32'd15, 32'd21));
    send_block(pack6(32'd10, 32'd10, 32'd10, 32'd10, 32'd20, 32'd15));
    send_block(pack6(32'd10, 32'd10, 32'd10, 32'd10, 32'd10, 32'd20));
    // background below foreground
    send_block(pack6(32'd100, 32'd50, 32'd75, 32'd76, 32'd74, '1));
    send_block(pack6('1, 32'hFFFFFFFD, 32'hFFFFFFFE, 32'h0, '1, 32'hFFFFFFFC));
    send_block(pack6($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    send_block(pack6($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    directed = sent;
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 88 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_block(random_block());
    end

    wait_drained();
    repeat (12) @(posedge clk);

    $display("summary: %0d pixel blocks (%0d directed), %0d results checked, %0d mismatches",
             sent, directed, checked, errors);
    $display("random blocks mixed full-range, two-color, midpoint-tie, uniform and extreme words");
    if (errors == 0 && pending == 0) begin
      $display("PASS sextant_two_color_quantizer_core");
    end else begin
      $display("FAIL sextant_two_color_quantizer_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
